### sv/tnst_pkg.sv
// Shared types and constants for the top-N score tracker.
// Holds field widths, operation codes and the cell link structs.
// No dependencies; imported by tnst_cell and top_n_score_tracker.
package tnst_pkg;

  // Field widths of the item ports
  localparam int KIND_W  = 2;
  localparam int TAG_W   = 16;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 3;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 4;
  localparam int CAP_W   = 4;

  // Build-time depth and capacity register reset
  localparam int MAX_ENTRIES_DEF = 8;
  localparam int CAP_RESET       = 8;

  // Operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // One stored entry, also the data handed from cell to cell
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic ins_en;    // an add is being kept this cycle
    logic occupied;  // cell index is below the stored count
  } cell_ctl_t;

endpackage

### sv/tnst_cell.sv
// One cell of the sorted chain: holds one entry and compares it with the
// incoming score. Takes the new entry or its upper neighbor's on insert.
// Depends on tnst_pkg.
module tnst_cell (
  input  logic               clk,
  input  tnst_pkg::cell_ctl_t ctl,
  input  tnst_pkg::entry_t   new_entry,
  input  tnst_pkg::entry_t   prev_entry,
  input  logic               prev_beat,
  output tnst_pkg::entry_t   entry,
  output logic               beat
);
  import tnst_pkg::*;

  // New score goes at or above this cell: empty, or strictly higher
  assign beat = !ctl.occupied || (new_entry.score > entry.score);

  // First beaten cell takes the new entry, cells below it shift down
  always_ff @(posedge clk) begin
    if (ctl.ins_en && beat) begin
      entry <= prev_beat ? prev_entry : new_entry;
    end
  end

endmodule

### sv/top_n_score_tracker.sv
// Top-N score tracker: a sorted list of the best score/tag pairs.
// Depends on tnst_pkg and tnst_cell.
//
// Usage:
//   Input channel (in_valid/in_stall) carries kind, tag, score and rank.
//   kind selects add, clear, read or no operation. Every item yields one
//   result on the output channel (out_valid/out_stall): position of an
//   add (MAX_ENTRIES when not kept), count after the item, and on a read
//   read_tag, read_score and read_ok.
//   Config channel (cfg_valid/cfg_ready) writes capacity; cfg_ready is
//   always high. Write it only while no item is in flight. A lower
//   capacity trims the stored count at once.
//   Results are registered: out_valid rises in the cycle after accept.
//   Throughput: one item per cycle while no result is held under out_stall;
//   all cells compare against the new score in parallel and shift in the same cycle, so the cell row sets the rate.
//   Stall: while a result waits under out_stall, in_stall is raised and
//   the held result is kept unchanged.
//   Reset (rst, synchronous): list empty, capacity 8 (limited to
//   MAX_ENTRIES), no result pending.
module top_n_score_tracker #(
  parameter int MAX_ENTRIES = tnst_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tnst_pkg::CAP_W-1:0]        capacity,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tnst_pkg::KIND_W-1:0]       kind,
  input  logic [tnst_pkg::TAG_W-1:0]        tag,
  input  logic signed [tnst_pkg::SCORE_W-1:0] score,
  input  logic [tnst_pkg::RANK_W-1:0]       rank,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tnst_pkg::POS_W-1:0]        position,
  output logic [tnst_pkg::COUNT_W-1:0]      count,
  output logic [tnst_pkg::TAG_W-1:0]        read_tag,
  output logic signed [tnst_pkg::SCORE_W-1:0] read_score,
  output logic                              read_ok
);
  import tnst_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Control state
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] stored_count_next;
  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] eff_cap_wr;

  logic   in_accept;
  kind_t  kind_op;
  entry_t new_entry;

  // Cell row links
  entry_t    cell_entry [MAX_ENTRIES];
  logic      cell_beat  [MAX_ENTRIES];
  cell_ctl_t cell_ctl   [MAX_ENTRIES];

  logic [CNT_W-1:0] ins_pos;
  logic             kept;
  logic             rd_hit;
  entry_t           rd_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign kind_op   = kind_t'(kind);
  assign new_entry = '{score: score, tag: tag};

  // Effective capacity of a written value: zero acts as one, clip to depth
  always_comb begin
    if (capacity == '0) begin
      eff_cap_wr = CNT_W'(1);
    end else if (EXT_W'(capacity) > EXT_W'(MAX_ENTRIES)) begin
      eff_cap_wr = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap_wr = CNT_W'(capacity);
    end
  end

  // Insert rank: first beaten cell, beat flags form a thermometer
  always_comb begin
    ins_pos = CNT_W'(MAX_ENTRIES);
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (cell_beat[i]) begin
        ins_pos = CNT_W'(i);
      end
    end
  end

  assign kept = (kind_op == KIND_ADD) && (ins_pos < eff_cap);

  // Cell row
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    assign cell_ctl[g].ins_en   = in_accept && kept;
    assign cell_ctl[g].occupied = (CNT_W'(g) < stored_count);

    if (g == 0) begin : g_head
      tnst_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[g]),
        .new_entry  (new_entry),
        .prev_entry (new_entry),
        .prev_beat  (1'b0),
        .entry      (cell_entry[g]),
        .beat       (cell_beat[g])
      );
    end else begin : g_body
      tnst_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[g]),
        .new_entry  (new_entry),
        .prev_entry (cell_entry[g-1]),
        .prev_beat  (cell_beat[g-1]),
        .entry      (cell_entry[g]),
        .beat       (cell_beat[g])
      );
    end
  end

  // Read select over the row
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (RANK_W'(i) == rank && i < (1 << RANK_W)) begin
        rd_entry = cell_entry[i];
      end
    end
  end

  assign rd_hit = (kind_op == KIND_READ) && (32'(rank) < 32'(stored_count))
                  && (32'(rank) < 32'(MAX_ENTRIES));

  // Stored count after this item
  always_comb begin
    stored_count_next = stored_count;
    case (kind_op)
      KIND_ADD: begin
        if (kept && stored_count < eff_cap) begin
          stored_count_next = stored_count + CNT_W'(1);
        end
      end
      KIND_CLEAR: stored_count_next = '0;
      default:    stored_count_next = stored_count;
    endcase
  end

  // Count and capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      eff_cap      <= (CAP_RESET > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(CAP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      eff_cap <= eff_cap_wr;
      if (stored_count > eff_cap_wr) begin
        stored_count <= eff_cap_wr;
      end
    end else if (in_accept) begin
      stored_count <= stored_count_next;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      position   <= kept ? POS_W'(ins_pos) : POS_W'(MAX_ENTRIES);
      count      <= COUNT_W'(stored_count_next);
      read_ok    <= rd_hit;
      read_tag   <= rd_hit ? rd_entry.tag : '0;
      read_score <= rd_hit ? rd_entry.score : '0;
    end
  end

endmodule
